### design/assert_macros.svh
// Assertion macros shared by the sample ring design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define SRDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define SRDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/srds_pkg.sv
// Shared types, constants and codes for the sample ring with drop statistics.
package srds_pkg;

  // Ring geometry
  localparam int DEPTH     = 1024;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int MAX_SLICE = 64;
  localparam int SLICE_W   = $clog2(MAX_SLICE + 1);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Field widths
  localparam int WIN_W     = 34;
  localparam int TIME_W    = 64;
  localparam int BODY_W    = 64;
  localparam int CNT_W     = 32;
  localparam int NUM_CNT   = 6;
  localparam int MAXREQ_W  = 7;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 34'd10000000000;

  // Stream widths
  localparam int IN_DATA_BITS  = 2 + TIME_W + BODY_W + MAXREQ_W;
  localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = 2 + TIME_W + BODY_W + NUM_CNT * CNT_W;
  localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_W   = 3;

  // Input function select
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Sample opcodes
  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_INSERT  = 2'd1;
  localparam logic [1:0] OP_LATENCY = 2'd2;
  localparam logic [1:0] OP_OTHER   = 2'd3;

  // Counter bank offsets: picked first, dropped after
  localparam logic [2:0] CNT_PICK_BASE = 3'd0;
  localparam logic [2:0] CNT_DROP_BASE = 3'd3;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_STORED  = 2'd0,
    KIND_DROPPED = 2'd1,
    KIND_ITEM    = 2'd2,
    KIND_EMPTY   = 2'd3
  } kind_t;

  typedef logic [NUM_CNT-1:0][CNT_W-1:0] cnt_vec_t;

  // One ring entry
  typedef struct packed {
    logic [BODY_W-1:0] payload;
    logic [TIME_W-1:0] stime;
    logic [1:0]        opcode;
  } entry_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic               is_read;
    logic [SLICE_W-1:0] n;
    logic               stored;
    logic               report;
    entry_t             entry;
    cnt_vec_t           counts;
  } cmd_t;

  // Result transaction handed from back to top
  typedef struct packed {
    kind_t    kind;
    logic     last;
    logic     report;
    entry_t   item;
    cnt_vec_t counts;
  } res_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### design/srds_front.sv
// Front end: accepts samples and read requests, tracks occupancy and window statistics.
module srds_front import srds_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [1:0]          in_opcode,
  input  logic [TIME_W-1:0]   in_time,
  input  logic [BODY_W-1:0]   in_payload,
  input  logic [MAXREQ_W-1:0] in_max,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [WIN_W-1:0]    cfg_data,
  input  q_stat_t             q_stat,
  output logic                q_push,
  output cmd_t                q_cmd
);

  localparam int MW = (PTR_W > SLICE_W) ? PTR_W : SLICE_W;

  logic [WIN_W-1:0]   window_ns;
  logic [TIME_W-1:0]  window_start;
  logic [PTR_W-1:0]   used;
  cnt_vec_t           cnt;

  logic               accept;
  logic [SLICE_W-1:0] req_clamp;
  logic [SLICE_W-1:0] n_pop;
  logic               stored;
  logic [2:0]         cidx;
  cnt_vec_t           bumped;
  logic [TIME_W-1:0]  elapsed;
  logic               report;
  logic [PTR_W-1:0]   used_next;
  cnt_vec_t           cnt_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_stat.full;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept;

  // Classification of the incoming transaction
  always_comb begin
    req_clamp = (in_max > MAXREQ_W'(MAX_SLICE)) ? SLICE_W'(MAX_SLICE)
                                                : in_max[SLICE_W-1:0];
    n_pop = (MW'(used) < MW'(req_clamp)) ? SLICE_W'(used) : req_clamp;
    stored = (used != PTR_W'(DEPTH - 1));

    // saturating per-opcode count
    cidx   = (stored ? CNT_PICK_BASE : CNT_DROP_BASE) + {1'b0, in_opcode};
    bumped = cnt;
    if (in_opcode != OP_OTHER && bumped[cidx] != '1) begin
      bumped[cidx] = bumped[cidx] + 1'b1;
    end

    // window check for read and insert samples only
    elapsed = in_time - window_start;
    report  = (in_opcode == OP_READ || in_opcode == OP_INSERT) &&
              (elapsed > TIME_W'(window_ns));

    if (in_func == FUNC_READ) begin
      used_next = used - PTR_W'(n_pop);
      cnt_next  = cnt;
    end else begin
      used_next = stored ? used + 1'b1 : used;
      cnt_next  = report ? '0 : bumped;
    end

    q_cmd.is_read       = (in_func == FUNC_READ);
    q_cmd.n             = n_pop;
    q_cmd.stored        = stored;
    q_cmd.report        = (in_func == FUNC_PUSH) && report;
    q_cmd.entry.opcode  = in_opcode;
    q_cmd.entry.stime   = in_time;
    q_cmd.entry.payload = in_payload;
    q_cmd.counts        = (in_func == FUNC_PUSH && report) ? bumped : '0;
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ns    <= WINDOW_RESET;
      window_start <= '0;
      used         <= '0;
      cnt          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_ns <= cfg_data;
      end
      if (accept) begin
        used <= used_next;
        cnt  <= cnt_next;
        if (in_func == FUNC_PUSH && report) begin
          window_start <= in_time;
        end
      end
    end
  end

endmodule

### design/srds_queue.sv
// Short command queue that decouples the front end from the ring back end.
module srds_queue import srds_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  output q_stat_t stat,
  input  logic    pop,
  output logic    head_valid,
  output cmd_t    head
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_idx;
  logic [QPTR_W-1:0] rd_idx;
  logic [QPTR_W:0]   count;

  assign stat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign head_valid = !stat.empty;
  assign head       = slots[rd_idx];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= wr_idx + 1'b1;
      end
      if (pop) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= push_cmd;
    end
  end

endmodule

### design/srds_back.sv
// Back end: owns the ring memory, executes pushes and read slices, drives results.
module srds_back import srds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  cmd_t head,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  entry_t             ring [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [SLICE_W-1:0] k;
  entry_t             rd_entry;

  // Stage 1: result header waiting for memory data
  logic               s1_valid;
  res_t               s1;

  logic               s1_adv;
  logic               s1_free;
  logic               go;
  logic               is_item;
  logic               last_item;
  logic               mem_we;
  logic               mem_re;
  res_t               s1_load;
  res_t               s1_out;

  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign s1_free   = !s1_valid || s1_adv;
  assign go        = head_valid && s1_free;
  assign is_item   = head.is_read && (head.n != '0);
  assign last_item = (({1'b0, k} + 1'b1) == {1'b0, head.n});
  assign pop       = go && (!is_item || last_item);
  assign mem_we    = go && !head.is_read && head.stored;
  assign mem_re    = go && is_item;

  // Header of the next result
  always_comb begin
    s1_load      = '0;
    s1_load.last = 1'b1;
    if (!head.is_read) begin
      s1_load.kind   = head.stored ? KIND_STORED : KIND_DROPPED;
      s1_load.report = head.report;
      s1_load.counts = head.counts;
    end else if (is_item) begin
      s1_load.kind = KIND_ITEM;
      s1_load.last = last_item;
    end else begin
      s1_load.kind = KIND_EMPTY;
    end
  end

  // Stage 1 result with the popped sample filled in
  always_comb begin
    s1_out      = s1;
    s1_out.item = (s1.kind == KIND_ITEM) ? rd_entry : '0;
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wr_ptr] <= head.entry;
    end
    if (mem_re) begin
      rd_entry <= ring[rd_ptr];
    end
  end

  // Pointers, slice counter and result stages
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      k         <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mem_we) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (mem_re) begin
        rd_ptr <= rd_ptr + 1'b1;
        k      <= last_item ? '0 : k + 1'b1;
      end
      if (go) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (go) begin
      s1 <= s1_load;
    end
    if (s1_adv) begin
      out_res <= s1_out;
    end
  end

endmodule

### design/sample_ring_with_drop_stats.sv
// Top level of the sample ring with per-window drop statistics.
//
//  channel  | signals                         | transaction when
//  ---------+---------------------------------+-------------------------------
//  s_axis   | tvalid tready tdata tuser       | tvalid && tready
//  m_axis   | tvalid tready tdata tuser tlast | tvalid && tready
//  cfg      | cfg_valid cfg_ready cfg_data    | cfg_valid && cfg_ready
//
// A push gives one result; a read slice gives max(1, n) results, one popped sample per
// cycle through the single ring read port while the output does not stall.
// The front accepts one transaction per cycle while the 4-entry command queue has room.
// m_axis_tvalid rises via the command queue, stage 1 (memory read) and output register.
// Reset (rst, synchronous) empties ring and queue, clears counters and window start,
// loads window_ns with 10000000000; output stalls back up through the queue to tready.
`include "assert_macros.svh"

module sample_ring_with_drop_stats import srds_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // opcode[1:0], sample_time[65:2], payload[129:66], max_items[136:130], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // func[0]
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_opcode[1:0], out_time[65:2], out_payload[129:66], picked_reads[161:130],
  // picked_inserts[193:162], picked_latency[225:194], dropped_reads[257:226],
  // dropped_inserts[289:258], dropped_latency[321:290], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // kind[1:0], window_report[2]
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [WIN_W-1:0]       cfg_data
);

  q_stat_t q_stat;
  logic    q_push;
  cmd_t    q_cmd;
  logic    q_pop;
  logic    q_head_valid;
  cmd_t    q_head;
  res_t    res;

  logic    in_xfer;
  logic    out_push;
  logic    out_empty;
  logic    out_report;
  logic    out_clean;

  srds_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_func    (s_axis_tuser),
    .in_opcode  (s_axis_tdata[1:0]),
    .in_time    (s_axis_tdata[2 +: TIME_W]),
    .in_payload (s_axis_tdata[2 + TIME_W +: BODY_W]),
    .in_max     (s_axis_tdata[2 + TIME_W + BODY_W +: MAXREQ_W]),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  srds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .stat       (q_stat),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  srds_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (res)
  );

  // Result packing
  assign m_axis_tdata = OUT_TDATA_W'({res.counts, res.item.payload, res.item.stime,
                                      res.item.opcode});
  assign m_axis_tuser = {res.report, res.kind};
  assign m_axis_tlast = res.last;

  // Terms used by the checks
  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_push   = m_axis_tvalid && (res.kind == KIND_STORED || res.kind == KIND_DROPPED);
  assign out_empty  = m_axis_tvalid && (res.kind == KIND_EMPTY);
  assign out_report = m_axis_tvalid && m_axis_tuser[2];
  assign out_clean  = m_axis_tlast && (m_axis_tdata == '0);

  // Checks
  `SRDS_ASSERT_IMP(a_push_single, out_push, m_axis_tlast, "push result without last")
  `SRDS_ASSERT_IMP(a_report_push_only, out_report, out_push, "report on a read result")
  `SRDS_ASSERT_IMP(a_empty_clean, out_empty, out_clean, "empty read result not clean")
  `SRDS_ASSERT_NXT(a_queue_filled, in_xfer, q_head_valid, "transaction not queued")

endmodule
